/* rtl/ogu_pkg.sv */
// ----------------------------------------------------------------------------
// ogu_pkg: shared types and constants for the occupancy grid update block
// Grid geometry, cell codes, item kinds, result status codes, register indexes.
// ----------------------------------------------------------------------------
package ogu_pkg;

	localparam int NUM_ROWS = 256;
	localparam int NUM_COLS = 1024;
	localparam int GRID_CELLS = NUM_ROWS * NUM_COLS;
	localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
	localparam int ADDR_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

	// divider geometry: 32-bit dividend, 16-bit divisor
	localparam int DVD_W = 32;
	localparam int DVS_W = 16;
	localparam int STEP_W = $clog2(DVD_W);

	// cell storage codes
	localparam logic [1:0] CODE_UNKNOWN  = 2'd0;
	localparam logic [1:0] CODE_OBSTACLE = 2'd1;
	localparam logic [1:0] CODE_FREE     = 2'd2;

	localparam logic [7:0] VAL_OBSTACLE = 8'd0;
	localparam logic [7:0] VAL_UNKNOWN  = 8'd127;
	localparam logic [7:0] VAL_FREE     = 8'd255;

	// item kinds
	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_RANGE   = 3'd2;
	localparam logic [2:0] ST_READ    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_POLAR   = 3'd0;
	localparam logic [2:0] REG_CELL    = 3'd1;
	localparam logic [2:0] REG_THRESH  = 3'd2;
	localparam logic [2:0] REG_DORG    = 3'd3;
	localparam logic [2:0] REG_LORG    = 3'd4;
	localparam logic [2:0] REG_ROWS    = 3'd5;
	localparam logic [2:0] REG_COLS    = 3'd6;

	typedef struct packed {
		logic               polar;
		logic [15:0]        divisor;   // cell size, zero replaced by one
		logic signed [31:0] thresh;
		logic [15:0]        dorg;
		logic signed [31:0] lorg;
		logic [8:0]         rows;
		logic [10:0]        cols;
	} cfg_t;

	typedef struct packed {
		logic [7:0] cell_row;
		logic [9:0] cell_col;
		logic [7:0] cell_value;
		logic       obstacle_hit;
		logic [2:0] status;
	} result_t;

	function automatic logic [7:0] code_to_val(input logic [1:0] code);
		logic [7:0] v;
		unique case (code)
			CODE_OBSTACLE: v = VAL_OBSTACLE;
			CODE_FREE:     v = VAL_FREE;
			default:       v = VAL_UNKNOWN;
		endcase
		return v;
	endfunction

endpackage

/* rtl/ogu_ram.sv */
// ----------------------------------------------------------------------------
// ogu_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ogu_ram #(
	parameter int ADDR_W = 18,
	parameter int DATA_W = 2
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* rtl/ogu_div.sv */
// ----------------------------------------------------------------------------
// ogu_div: iterative restoring divider
// Unsigned 32 by 16 bit, one quotient bit per cycle, done pulses on the last step.
// ----------------------------------------------------------------------------
module ogu_div
	import ogu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic             busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] work_q;   // dividend bits shift out, quotient bits shift in
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             take;

	assign trial = {rem_q, work_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			work_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			work_q <= {work_q[DVD_W-2:0], take};
		end
	end

	assign quotient = work_q;

endmodule

/* rtl/ogu_cfg.sv */
// ----------------------------------------------------------------------------
// ogu_cfg: configuration register file
// Write-only registers, loaded by index; values masked to register width.
// ----------------------------------------------------------------------------
module ogu_cfg
	import ogu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic               polar_q;
	logic [15:0]        cell_q;
	logic signed [31:0] thresh_q;
	logic [15:0]        dorg_q;
	logic signed [31:0] lorg_q;
	logic [8:0]         rows_q;
	logic [10:0]        cols_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_q  <= 1'b1;
			cell_q   <= 16'd100;
			thresh_q <= '0;
			dorg_q   <= '0;
			lorg_q   <= '0;
			rows_q   <= 9'd256;
			cols_q   <= 11'd1024;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_POLAR:  polar_q  <= cfg_data[0];
				REG_CELL:   cell_q   <= cfg_data[15:0];
				REG_THRESH: thresh_q <= cfg_data;
				REG_DORG:   dorg_q   <= cfg_data[15:0];
				REG_LORG:   lorg_q   <= cfg_data;
				REG_ROWS:   rows_q   <= cfg_data[8:0];
				REG_COLS:   cols_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.polar   = polar_q;
		cfg.divisor = (cell_q == '0) ? 16'd1 : cell_q;
		cfg.thresh  = thresh_q;
		cfg.dorg    = dorg_q;
		cfg.lorg    = lorg_q;
		cfg.rows    = rows_q;
		cfg.cols    = cols_q;
	end

endmodule

/* rtl/occupancy_grid_update.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_update: occupancy grid of obstacle / free / unknown cells
// Point updates, single-cell reads and whole-grid clears over a cell memory.
// ----------------------------------------------------------------------------
// Usage:
//  - Input items arrive on s_* (kind in s_tuser). A point item maps to one grid
//    cell and updates it when in range; a read item returns one cell; a clear item
//    resets the whole grid to unknown. Each item except kind 3 yields one result
//    item on m_* (status in m_tuser). Kind 3 is taken and dropped.
//  - Registers are written through cfg_wr_en / cfg_index / cfg_data while idle.
//  - A point item with depth runs two 32-step restoring dividers for row and
//    column side by side, then, if in range, a read-modify-write of the cell
//    memory. A read item reads one cell; a zero-depth point, an out-of-range
//    read or a clear goes straight to the result register.
//  - One item at a time: s_tready is high only in the idle state, which is
//    re-entered as the result is loaded; kind 3 leaves the block idle.
//  - The result register stays loaded while the receiver stalls; the next item
//    is still accepted and processed, then waits with s_tready low until the
//    register drains.
//  - Reset and every clear item start a clearing pass that writes unknown to
//    all 262144 cells, one cell a cycle. No input item is accepted during the
//    pass; the clear item's result is loaded as it starts.
// ----------------------------------------------------------------------------
module occupancy_grid_update
	import ogu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata: pixel_col[9:0], lateral_x[41:10], height_y[73:42], depth_z[89:74],
	//          read_row[97:90], read_col[107:98], zero pad [111:108]
	input  logic [111:0] s_tdata,
	// s_tuser: kind[1:0]
	input  logic [1:0]   s_tuser,
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: cell_row[7:0], cell_col[17:8], cell_value[25:18],
	//          obstacle_hit[26], zero pad [31:27]
	output logic [31:0]  m_tdata,
	// m_tuser: status[2:0]
	output logic [2:0]   m_tuser,
	// configuration
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DIV   = 6'b000100,
		S_UPD   = 6'b001000,
		S_RD    = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	// unpacked input fields
	logic [9:0]         in_pcol;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic [15:0]        in_z;
	logic [7:0]         in_rrow;
	logic [9:0]         in_rcol;
	logic [1:0]         in_kind;
	logic               accept;

	assign in_pcol = s_tdata[9:0];
	assign in_x    = s_tdata[41:10];
	assign in_y    = s_tdata[73:42];
	assign in_z    = s_tdata[89:74];
	assign in_rrow = s_tdata[97:90];
	assign in_rcol = s_tdata[107:98];
	assign in_kind = s_tuser;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	ogu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// ---- index differences at accept ----
	// negative differences give index 0 only when |diff| < divisor
	logic signed [16:0] row_diff;
	logic signed [32:0] col_diff;
	logic [16:0]        row_mag;
	logic [32:0]        col_mag;
	logic               row_neg, col_neg;
	logic               row_bad, col_bad;
	logic [DVD_W-1:0]   row_dvd, col_dvd;
	logic               low_pt;
	logic               div_start;

	always_comb begin
		row_diff = $signed({1'b0, in_z}) - $signed({1'b0, cfg.dorg});
		col_diff = $signed({in_x[31], in_x}) - $signed({cfg.lorg[31], cfg.lorg});
		row_neg  = row_diff[16];
		col_neg  = col_diff[32];
		row_mag  = 17'(-row_diff);
		col_mag  = 33'(-col_diff);
		row_bad  = row_neg && (row_mag >= {1'b0, cfg.divisor});
		col_bad  = !cfg.polar && col_neg && (col_mag >= {17'b0, cfg.divisor});
		row_dvd  = row_neg ? '0 : DVD_W'(row_diff[15:0]);
		col_dvd  = col_neg ? '0 : col_diff[31:0];
		// polar grids include the threshold, cartesian grids exclude it
		low_pt   = cfg.polar ? (in_y <= $signed(cfg.thresh)) : (in_y < $signed(cfg.thresh));
	end

	assign div_start = accept && (in_kind == KIND_POINT) && (in_z != '0);

	logic             row_done, col_done;
	logic [DVD_W-1:0] row_quo, col_quo;

	ogu_div u_div_row (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (row_dvd),
		.divisor  (cfg.divisor),
		.done     (row_done),
		.quotient (row_quo)
	);

	ogu_div u_div_col (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (col_dvd),
		.divisor  (cfg.divisor),
		.done     (col_done),
		.quotient (col_quo)
	);

	// ---- per-item registers ----
	logic             row_bad_q, col_bad_q, hit_q;
	logic [9:0]       pcol_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             clr_pend_q;
	logic [ADDR_W-1:0] clr_q;
	result_t          res_q;
	logic             div_last;   // dividers finished this cycle
	logic             out_load;   // result register takes the pending result

	assign div_last = (state_q == S_DIV) && row_done && col_done;
	assign out_load = (state_q == S_OUT) && (!m_tvalid || m_tready);

	// index range check after the dividers
	logic [DVD_W-1:0] col_idx;
	logic             idx_ok;

	always_comb begin
		col_idx = cfg.polar ? DVD_W'(pcol_q) : col_quo;
		idx_ok  = !row_bad_q && !col_bad_q
			&& (row_quo < DVD_W'(cfg.rows)) && (row_quo < DVD_W'(NUM_ROWS))
			&& (col_idx < DVD_W'(cfg.cols)) && (col_idx < DVD_W'(NUM_COLS));
	end

	logic read_ok;
	assign read_ok = (32'(in_rrow) < 32'(NUM_ROWS)) && (32'(in_rcol) < 32'(NUM_COLS));

	// ---- cell memory ----
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [1:0]        ram_wdata, ram_rdata;
	logic [1:0]        new_code;

	always_comb begin
		// obstacles stick; anything else not low becomes free
		if (hit_q) begin
			new_code = CODE_OBSTACLE;
		end else if (ram_rdata == CODE_OBSTACLE) begin
			new_code = CODE_OBSTACLE;
		end else begin
			new_code = CODE_FREE;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = CODE_UNKNOWN;
		ram_raddr = ADDR_W'(ADDR_W'(row_quo) * ADDR_W'(NUM_COLS) + ADDR_W'(col_idx));
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_raddr = ADDR_W'(ADDR_W'(in_rrow) * ADDR_W'(NUM_COLS) + ADDR_W'(in_rcol));
			end
			S_UPD: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(NUM_COLS) + ADDR_W'(col_q));
				ram_wdata = new_code;
			end
			default: ;
		endcase
	end

	ogu_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (2)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- next result contents ----
	result_t res_init, res_range, res_upd, res_rd;

	always_comb begin
		// at accept: zero-depth point, unreadable cell or clear
		res_init = '0;
		unique case (in_kind)
			KIND_POINT: res_init.status = ST_ZERO;
			KIND_READ:  res_init.status = ST_RANGE;
			default: begin
				res_init.status     = ST_CLEARED;
				res_init.cell_value = VAL_UNKNOWN;
			end
		endcase
		res_range        = '0;
		res_range.status = ST_RANGE;
		res_upd              = '0;
		res_upd.cell_row     = 8'(row_q);
		res_upd.cell_col     = 10'(col_q);
		res_upd.cell_value   = code_to_val(new_code);
		res_upd.obstacle_hit = hit_q;
		res_upd.status       = ST_UPDATED;
		res_rd            = '0;
		res_rd.cell_row   = 8'(row_q);
		res_rd.cell_col   = 10'(col_q);
		res_rd.cell_value = code_to_val(ram_rdata);
		res_rd.status     = ST_READ;
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			clr_pend_q <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(GRID_CELLS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						clr_pend_q <= 1'b0;
						unique case (in_kind)
							KIND_POINT: state_q <= (in_z == '0) ? S_OUT : S_DIV;
							KIND_READ:  state_q <= read_ok ? S_RD : S_OUT;
							KIND_CLEAR: begin
								clr_pend_q <= 1'b1;
								state_q    <= S_OUT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (row_done && col_done) begin
						state_q <= idx_ok ? S_UPD : S_OUT;
					end
				end
				S_UPD: begin
					state_q <= S_OUT;
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= clr_pend_q ? S_CLEAR : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_bad_q <= row_bad;
			col_bad_q <= col_bad;
			hit_q     <= low_pt;
			pcol_q    <= in_pcol;
			row_q     <= ROW_W'(in_rrow);
			col_q     <= COL_W'(in_rcol);
			res_q     <= res_init;
		end else if (div_last) begin
			row_q <= ROW_W'(row_quo);
			col_q <= COL_W'(col_idx);
			res_q <= res_range;
		end else if (state_q == S_UPD) begin
			res_q <= res_upd;
		end else if (state_q == S_RD) begin
			res_q <= res_rd;
		end
		if (out_load) begin
			m_tdata <= {5'b0, res_q.obstacle_hit, res_q.cell_value,
				res_q.cell_col, res_q.cell_row};
			m_tuser <= res_q.status;
		end
	end

endmodule

/* sim/occupancy_grid_update_tb.sv */
// ----------------------------------------------------------------------------
// occupancy_grid_update_tb: self-checking bench for the occupancy grid update
// Drives point, read, clear and unused-kind items over the input stream. A
// cell-level copy of the grid predicts every result item. Several register
// settings are covered, extremes among them, and both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module occupancy_grid_update_tb;
	import ogu_pkg::*;

	// the one kind the block takes and drops
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	// run aborts here; the slowest correct run stays well under it
	localparam int CYCLE_LIMIT = 4000000;
	// cycles to wait once no result item is still owed
	localparam int SETTLE_CYCLES = 40;

	// one input item, fields as they travel on s_tdata / s_tuser
	typedef struct {
		logic [1:0]         kind;
		logic [9:0]         pixel_col;
		logic signed [31:0] lateral_x;
		logic signed [31:0] height_y;
		logic [15:0]        depth_z;
		logic [7:0]         read_row;
		logic [9:0]         read_col;
	} grid_item_t;

	// ------------------------------------------------------------------------
	// grid predictor plus the queue of result items still owed by the block
	// ------------------------------------------------------------------------
	class occupancy_model;
		bit                 polar;
		bit [15:0]          cell_size;
		bit signed [31:0]   thresh;
		bit [15:0]          dorg;
		bit signed [31:0]   lorg;
		bit [8:0]           rows;
		bit [10:0]          cols;
		logic [7:0]         cells [GRID_CELLS];
		result_t            expected_cells [$];
		int                 touched [$];   // recently updated cell addresses
		int                 errors;

		function new();
			polar = 1'b1;
			cell_size = 16'd100;
			thresh = '0;
			dorg = '0;
			lorg = '0;
			rows = 9'd256;
			cols = 11'd1024;
			errors = 0;
			foreach (cells[i])
				cells[i] = VAL_UNKNOWN;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_POLAR:  polar = data[0];
				REG_CELL:   cell_size = data[15:0];
				REG_THRESH: thresh = data;
				REG_DORG:   dorg = data[15:0];
				REG_LORG:   lorg = data;
				REG_ROWS:   rows = data[8:0];
				REG_COLS:   cols = data[10:0];
				default: ;
			endcase
		endfunction

		// truncating quotient; a negative difference is only usable when it
		// rounds to zero
		function bit grid_index(longint diff, longint div, output longint idx);
			if (diff >= 0) begin
				idx = diff / div;
				return 1'b1;
			end
			idx = 0;
			return ((-diff) / div) == 0;
		endfunction

		function void take_item(grid_item_t it);
			result_t r;
			longint  div, row, col;
			bit      ok, low;
			int      addr;
			r = '0;
			case (it.kind)
				KIND_POINT: begin
					if (it.depth_z == 0) begin
						r.status = ST_ZERO;
					end else begin
						div = (cell_size == 0) ? longint'(1) : longint'(cell_size);
						ok = grid_index(longint'(it.depth_z) - longint'(dorg), div, row);
						if (polar)
							col = longint'(it.pixel_col);
						else
							ok = grid_index(longint'(it.lateral_x) - longint'(lorg),
								div, col) && ok;
						if (!ok || row >= rows || row >= NUM_ROWS ||
								col >= cols || col >= NUM_COLS) begin
							r.status = ST_RANGE;
						end else begin
							addr = int'(row) * NUM_COLS + int'(col);
							low = polar ? (it.height_y <= thresh) : (it.height_y < thresh);
							if (low)
								cells[addr] = VAL_OBSTACLE;
							else if (cells[addr] != VAL_OBSTACLE)
								cells[addr] = VAL_FREE;
							touched = {touched, addr};
							if (touched.size() > 64)
								void'(touched.pop_front());
							r.cell_row = row[7:0];
							r.cell_col = col[9:0];
							r.cell_value = cells[addr];
							r.obstacle_hit = low;
							r.status = ST_UPDATED;
						end
					end
				end
				KIND_READ: begin
					if (it.read_row >= NUM_ROWS || it.read_col >= NUM_COLS) begin
						r.status = ST_RANGE;
					end else begin
						r.cell_row = it.read_row;
						r.cell_col = it.read_col;
						r.cell_value = cells[int'(it.read_row) * NUM_COLS + int'(it.read_col)];
						r.status = ST_READ;
					end
				end
				KIND_CLEAR: begin
					foreach (cells[i])
						cells[i] = VAL_UNKNOWN;
					r.cell_value = VAL_UNKNOWN;
					r.status = ST_CLEARED;
				end
				default: return;   // unused kind: no result
			endcase
			expected_cells = {expected_cells, r};
		endfunction

		task report(string what, longint got, longint want);
			errors++;
			$display("ERROR %s: got %0d want %0d", what, got, want);
		endtask

		task check_cell(logic [31:0] data, logic [2:0] user);
			result_t want;
			if (expected_cells.size() == 0) begin
				report("result item with nothing pending", longint'(data), 0);
				return;
			end
			want = expected_cells.pop_front();
			if (data[7:0] !== want.cell_row)
				report("cell_row", longint'(data[7:0]), longint'(want.cell_row));
			if (data[17:8] !== want.cell_col)
				report("cell_col", longint'(data[17:8]), longint'(want.cell_col));
			if (data[25:18] !== want.cell_value)
				report("cell_value", longint'(data[25:18]), longint'(want.cell_value));
			if (data[26] !== want.obstacle_hit)
				report("obstacle_hit", longint'(data[26]), longint'(want.obstacle_hit));
			if (user !== want.status)
				report("status", longint'(user), longint'(want.status));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, DUT
	// ------------------------------------------------------------------------
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [31:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_wr_en = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	occupancy_model model;
	bit  calm = 1'b0;          // no idling on either side in the last phase
	int  results_seen = 0;
	int  cycles = 0;

	always #5 clk = ~clk;

	occupancy_grid_update u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("occupancy_grid_update: mismatch");
			$finish;
		end
	end

	// result side: every accepted result item goes to the checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			model.check_cell(m_tdata, m_tuser);
			results_seen++;
		end
	end

	// receiver readiness: random stall bursts, plus one long hold-off so the
	// result register backs up and the input side stalls
	initial begin : receiver
		int  stall_left;
		int  hold_left;
		bit  hold_done;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= 400) begin
				hold_done = 1'b1;
				hold_left = 599;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// driving tasks
	// ------------------------------------------------------------------------
	// field values come in as 32-bit words and are cut to their field widths
	function automatic grid_item_t mk(logic [1:0] kind, int pc, int x, int y, int z,
			int rr, int rc);
		grid_item_t it;
		it.kind = kind;
		it.pixel_col = 10'(pc);
		it.lateral_x = x;
		it.height_y = y;
		it.depth_z = 16'(z);
		it.read_row = 8'(rr);
		it.read_col = 10'(rc);
		return it;
	endfunction

	// offer one item, optionally after an idle burst; returns once accepted
	task automatic send(grid_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {4'b0, it.read_col, it.read_row, it.depth_z, it.height_y,
			it.lateral_x, it.pixel_col};
		do @(posedge clk); while (!s_tready);
		model.take_item(it);
	endtask

	// sender pauses until every result is back and the block is idle again
	// (a clear keeps s_tready low for its whole sweep of the grid)
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (model.expected_cells.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		model.write_reg(idx, data);
	endtask

	task automatic apply_config(bit polar, logic [15:0] cs, logic [31:0] thr,
			logic [15:0] dorg, logic [31:0] lorg, logic [8:0] rows, logic [10:0] cols);
		write_reg(REG_POLAR, {31'b0, polar});
		write_reg(REG_CELL, {16'b0, cs});
		write_reg(REG_THRESH, thr);
		write_reg(REG_DORG, {16'b0, dorg});
		write_reg(REG_LORG, lorg);
		write_reg(REG_ROWS, {23'b0, rows});
		write_reg(REG_COLS, {21'b0, cols});
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_config();
		bit          polar;
		logic [15:0] cs;
		logic [31:0] thr, lorg;
		logic [15:0] dorg;
		logic [8:0]  rows;
		logic [10:0] cols;
		polar = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 5))
			0: cs = 16'd0;
			1: cs = 16'd1;
			5: cs = 16'($urandom_range(1, 65535));
			default: cs = 16'($urandom_range(2, 400));
		endcase
		thr = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200) - 100;
		dorg = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom_range(0, 3000));
		lorg = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 2000) - 1000;
		rows = $urandom_range(0, 2) == 0 ? 9'd256 : 9'($urandom_range(1, 256));
		cols = $urandom_range(0, 2) == 0 ? 11'd1024 : 11'($urandom_range(1, 1024));
		apply_config(polar, cs, thr, dorg, lorg, rows, cols);
	endtask

	// point aimed at a cell inside (or just past) the grid in use
	function automatic grid_item_t aimed_point();
		longint d, row, col, zl, xl;
		int     nr, nc;
		logic signed [31:0] y;
		d = (model.cell_size == 0) ? longint'(1) : longint'(model.cell_size);
		nr = int'(model.rows);
		nc = int'(model.cols);
		// half the time stay in a small corner so cells get revisited
		if ($urandom_range(0, 1)) begin
			row = longint'($urandom_range(0, (nr < 8 ? nr : 8) - 1));
			col = longint'($urandom_range(0, (nc < 16 ? nc : 16) - 1));
		end else begin
			row = longint'($urandom_range(0, nr));
			col = longint'($urandom_range(0, nc));
		end
		zl = longint'(model.dorg) + row * d + longint'($urandom_range(0, 32'(d - 1)));
		if (zl > 65535)
			zl = 65535;
		if (zl == 0)
			zl = 1;
		xl = longint'(model.lorg) + col * d + longint'($urandom_range(0, 32'(d - 1)));
		// negative offset still inside cell zero
		if ($urandom_range(0, 9) == 0)
			xl = longint'(model.lorg) - longint'($urandom_range(0, 32'(d - 1)));
		case ($urandom_range(0, 3))
			0: y = model.thresh;
			1: y = model.thresh - 1;
			2: y = model.thresh + 1;
			default: y = $urandom();
		endcase
		return mk(KIND_POINT, model.polar ? int'(col) : int'($urandom()), int'(xl), y,
			int'(zl), $urandom(), $urandom());
	endfunction

	function automatic grid_item_t random_item();
		int  pick, addr;
		pick = $urandom_range(0, 99);
		if (pick < 58)
			return aimed_point();
		if (pick < 66)   // unaimed point, any field value
			return mk(KIND_POINT, $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom(),
				$urandom(), $urandom());
		if (pick < 69)
			return mk(KIND_POINT, $urandom(), $urandom(), $urandom(), 0,
				$urandom(), $urandom());
		if (pick < 96) begin
			if (model.touched.size() != 0 && $urandom_range(0, 9) < 7) begin
				addr = model.touched[$urandom_range(0, model.touched.size() - 1)];
				return mk(KIND_READ, $urandom(), $urandom(), $urandom(), $urandom(),
					addr / NUM_COLS, addr % NUM_COLS);
			end
			return mk(KIND_READ, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom());
		end
		return mk(KIND_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom());
	endfunction

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		model = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: polar, cell 100, threshold 0, full grid
		send(mk(KIND_READ, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_POINT, 0, 0, 0, 0, 0, 0));                       // no depth
		send(mk(KIND_POINT, 1023, -1, 0, 'hFFFF, 0, 0));               // row past grid
		send(mk(KIND_POINT, 5, 0, 0, 150, 0, 0));                      // y at limit: obstacle
		send(mk(KIND_POINT, 5, 0, 1, 150, 0, 0));                      // obstacle stays
		send(mk(KIND_POINT, 6, 0, 1, 100, 0, 0));                      // free
		send(mk(KIND_POINT, 1023, 32'h7FFFFFFF, 32'h7FFFFFFF, 25599, 0, 0));
		send(mk(KIND_POINT, 0, 32'h80000000, 32'h80000000, 1, 0, 0));
		send(mk(KIND_READ, 0, 0, 0, 0, 1, 5));
		send(mk(KIND_READ, 0, 0, 0, 0, 255, 1023));
		send(mk(KIND_READ, 0, 0, 0, 0, 1, 6));
		send(mk(KIND_UNUSED, '1, '1, '1, '1, '1, '1));
		send(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
		send(mk(KIND_READ, 0, 0, 0, 0, 1, 5));                         // unknown again

		// cartesian, small grid: strict threshold and truncation at cell edges
		wait_drained();
		apply_config(1'b0, 16'd100, 32'd10, 16'd50, -32'sd200, 9'd4, 11'd8);
		send(mk(KIND_POINT, 0, -32'sd299, 32'sd10, 1, 0, 0));          // rounds to (0,0)
		send(mk(KIND_POINT, 0, -32'sd300, 32'sd10, 60, 0, 0));         // column negative
		send(mk(KIND_POINT, 0, 32'sd599, 32'sd9, 449, 0, 0));          // (3,7) obstacle
		send(mk(KIND_POINT, 0, 32'sd600, 32'sd0, 449, 0, 0));          // column = cols
		send(mk(KIND_POINT, 0, 32'sd599, 32'sd0, 450, 0, 0));          // row = rows
		send(mk(KIND_READ, 0, 0, 0, 0, 3, 7));

		// cell size zero divides by one; extreme threshold and origins
		wait_drained();
		apply_config(1'b1, 16'd0, 32'h80000000, 16'hFFFF, 32'h7FFFFFFF, 9'd256, 11'd1024);
		send(mk(KIND_POINT, 1023, 0, 32'h80000000, 'hFFFF, 0, 0));
		send(mk(KIND_POINT, 3, 0, 0, 'hFFFE, 0, 0));
		send(mk(KIND_POINT, 2, 0, 32'h7FFFFFFF, 'hFFFF, 0, 0));

		// random phases, each with its own settings; the grid is cleared once
		for (int phase = 0; phase < 8; phase++) begin
			wait_drained();
			random_config();
			calm = (phase == 7);
			for (int i = 0; i < 235; i++) begin
				if (phase == 3 && i == 100)
					send(mk(KIND_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
						$urandom(), $urandom()));
				else
					send(random_item());
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (model.expected_cells.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (model.errors == 0 && model.expected_cells.size() == 0)
			$display("occupancy_grid_update: match");
		else
			$display("occupancy_grid_update: mismatch");
		$finish;
	end

endmodule
